FILE: design/wsh_pkg.sv
// shared types and constants for the websocket header parser
`timescale 1ns / 1ps

package wsh_pkg;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_EXT    = 2'd2,
    PH_KEY    = 2'd3
  } phase_t;

  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [3:0] HDR_BASE    = 4'd2;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] EXT64_END   = 4'd10;

  localparam logic [3:0] OP_RSV_LO = 4'h3;
  localparam logic [3:0] OP_RSV_HI = 4'h7;
  localparam logic [3:0] OP_LAST   = 4'hA;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [3:0]  header_length;
    logic [31:0] mask_key;
    logic [62:0] payload_length;
    logic        is_masked;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        status;
  } result_t;

endpackage

FILE: design/wsh_in_stage.sv
// input register for raw stream bytes
`timescale 1ns / 1ps

module wsh_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

FILE: design/wsh_parser_core.sv
// header field decode and parse state
`timescale 1ns / 1ps

module wsh_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  output logic              emit,
  output wsh_pkg::result_t  res
);

  wsh_pkg::phase_t phase, phase_next;
  logic [3:0]  bytes_seen, bytes_seen_next;
  logic [3:0]  bytes_required, bytes_required_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode_held, opcode_held_next;
  logic        mask_flag, mask_flag_next;
  logic [63:0] length_accum, length_accum_next;
  logic [31:0] key_accum, key_accum_next;

  logic [3:0]  op;
  logic [6:0]  len7;
  logic [3:0]  ext_end;
  logic [3:0]  seen_inc;
  logic        done_hdr;
  logic        done_err;
  logic [3:0]  err_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wsh_pkg::PH_FIRST;
      bytes_seen     <= '0;
      bytes_required <= wsh_pkg::HDR_BASE;
      fin_flag       <= 1'b0;
      opcode_held    <= '0;
      mask_flag      <= 1'b0;
      length_accum   <= '0;
      key_accum      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      bytes_seen     <= bytes_seen_next;
      bytes_required <= bytes_required_next;
      fin_flag       <= fin_flag_next;
      opcode_held    <= opcode_held_next;
      mask_flag      <= mask_flag_next;
      length_accum   <= length_accum_next;
      key_accum      <= key_accum_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_seen_next     = bytes_seen;
    bytes_required_next = bytes_required;
    fin_flag_next       = fin_flag;
    opcode_held_next    = opcode_held;
    mask_flag_next      = mask_flag;
    length_accum_next   = length_accum;
    key_accum_next      = key_accum;
    done_hdr            = 1'b0;
    done_err            = 1'b0;
    err_len             = '0;
    op                  = length_accum[3:0];
    len7                = data_byte[6:0];
    ext_end             = mask_flag ? (bytes_required - wsh_pkg::KEY_BYTES) : bytes_required;
    seen_inc            = bytes_seen + 4'd1;

    case (phase)
      wsh_pkg::PH_FIRST: begin
        length_accum_next = {56'd0, data_byte};
        bytes_seen_next   = 4'd1;
        phase_next        = wsh_pkg::PH_SECOND;
      end
      wsh_pkg::PH_SECOND: begin
        bytes_seen_next = wsh_pkg::HDR_BASE;
        if ((length_accum[6:4] != 3'd0) || (op > wsh_pkg::OP_LAST) ||
            (op inside {[wsh_pkg::OP_RSV_LO:wsh_pkg::OP_RSV_HI]})) begin
          done_err = 1'b1;
          err_len  = wsh_pkg::HDR_BASE;
        end else begin
          fin_flag_next       = length_accum[7];
          opcode_held_next    = op;
          mask_flag_next      = data_byte[7];
          bytes_required_next = wsh_pkg::HDR_BASE;
          if (len7 == wsh_pkg::LEN16_CODE) begin
            bytes_required_next = wsh_pkg::HDR_BASE + wsh_pkg::EXT16_BYTES;
            length_accum_next   = '0;
            phase_next          = wsh_pkg::PH_EXT;
          end else if (len7 == wsh_pkg::LEN64_CODE) begin
            bytes_required_next = wsh_pkg::HDR_BASE + wsh_pkg::EXT64_BYTES;
            length_accum_next   = '0;
            phase_next          = wsh_pkg::PH_EXT;
          end else begin
            length_accum_next = {57'd0, len7};
            phase_next        = wsh_pkg::PH_KEY;
          end
          if (data_byte[7]) begin
            bytes_required_next = bytes_required_next + wsh_pkg::KEY_BYTES;
          end
          done_hdr = (bytes_required_next <= wsh_pkg::HDR_BASE);
        end
      end
      wsh_pkg::PH_EXT: begin
        length_accum_next = {length_accum[55:0], data_byte};
        bytes_seen_next   = seen_inc;
        if (seen_inc >= ext_end) begin
          if ((ext_end == wsh_pkg::EXT64_END) && length_accum_next[63]) begin
            done_err = 1'b1;
            err_len  = seen_inc;
          end else begin
            phase_next = wsh_pkg::PH_KEY;
            done_hdr   = (seen_inc >= bytes_required);
          end
        end
      end
      wsh_pkg::PH_KEY: begin
        key_accum_next  = {key_accum[23:0], data_byte};
        bytes_seen_next = seen_inc;
        done_hdr        = (seen_inc >= bytes_required);
      end
      default: begin
        phase_next = wsh_pkg::PH_FIRST;
      end
    endcase

    res = '0;
    if (done_err) begin
      res.status        = wsh_pkg::STATUS_ERROR;
      res.header_length = err_len;
    end else begin
      res.status         = wsh_pkg::STATUS_OK;
      res.final_fragment = fin_flag_next;
      res.frame_opcode   = opcode_held_next;
      res.is_masked      = mask_flag_next;
      res.payload_length = length_accum_next[62:0];
      res.mask_key       = mask_flag_next ? key_accum_next : 32'd0;
      res.header_length  = bytes_seen_next;
    end

    // a finished header or an error starts the next frame from scratch
    if (done_err || done_hdr) begin
      phase_next          = wsh_pkg::PH_FIRST;
      bytes_seen_next     = '0;
      bytes_required_next = wsh_pkg::HDR_BASE;
      fin_flag_next       = 1'b0;
      opcode_held_next    = '0;
      mask_flag_next      = 1'b0;
      length_accum_next   = '0;
      key_accum_next      = '0;
    end
  end

  assign emit = done_err || done_hdr;

  a_no_result_on_first_byte: assert property (@(posedge clk) disable iff (rst)
    (phase == wsh_pkg::PH_FIRST) |-> !emit)
    else $error("result raised on first header byte");

  a_header_length_range: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |-> (res.header_length >= wsh_pkg::HDR_BASE))
    else $error("header length below minimum");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (emit && res.status) |-> (res.payload_length == '0 && res.mask_key == '0 &&
                              res.frame_opcode == '0 && !res.is_masked))
    else $error("error result carries header fields");

  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> (phase == wsh_pkg::PH_FIRST && key_accum == '0))
    else $error("parser did not restart after result");

endmodule

FILE: design/wsh_out_stage.sv
// result register on the output stream
`timescale 1ns / 1ps

module wsh_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  wsh_pkg::result_t  load_res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              advance,
  output wsh_pkg::result_t  out_res
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

FILE: design/websocket_header_parser.sv
// websocket frame header parser, one stream byte per transfer
// a result is loaded into the result register once the byte that completes it leaves the input register
// throughput: one byte per cycle while the output accepts results, set by the combinational
// parse step between the input register and the result register
// reset: synchronous, clears both valid flags and returns the parser to the first byte
`timescale 1ns / 1ps

module websocket_header_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // final_fragment, frame_opcode, is_masked,
                                        // payload_length, mask_key, header_length
  output logic          m_axis_tuser    // status
);

  logic             advance;
  logic             held_valid;
  logic [7:0]       held_byte;
  logic             emit;
  wsh_pkg::result_t core_res;
  wsh_pkg::result_t out_res;

  wsh_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsh_parser_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (held_valid && advance),
    .data_byte (held_byte),
    .emit      (emit),
    .res       (core_res)
  );

  wsh_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (held_valid),
    .load_valid (emit),
    .load_res   (core_res),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .advance    (advance),
    .out_res    (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {7'd0, out_res.header_length, out_res.mask_key,
                         out_res.payload_length, out_res.is_masked,
                         out_res.frame_opcode, out_res.final_fragment};

endmodule

FILE: sim/websocket_header_parser_checker.sv
// header checker: predicts parser results from input transfers and compares output transfers
`timescale 1ns / 1ps

module websocket_header_parser_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,   // final_fragment, frame_opcode, is_masked,
                                       // payload_length, mask_key, header_length
  input  logic         m_axis_tuser,   // status
  output int           errors,
  output int           outstanding
);

  localparam logic [3:0] FIRST_BYTES = 4'd1;

  wsh_pkg::phase_t ph;
  logic [3:0]  seen;
  logic [3:0]  need;
  logic        fin_q;
  logic [3:0]  op_q;
  logic        mask_q;
  logic [63:0] len_q;
  logic [31:0] key_q;

  wsh_pkg::result_t expected_headers[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void clear_parser();
    ph     = wsh_pkg::PH_FIRST;
    seen   = '0;
    need   = wsh_pkg::HDR_BASE;
    fin_q  = 1'b0;
    op_q   = '0;
    mask_q = 1'b0;
    len_q  = '0;
    key_q  = '0;
  endfunction

  function automatic wsh_pkg::result_t header_done();
    wsh_pkg::result_t r;
    r                = '0;
    r.status         = wsh_pkg::STATUS_OK;
    r.final_fragment = fin_q;
    r.frame_opcode   = op_q;
    r.is_masked      = mask_q;
    r.payload_length = len_q[62:0];
    r.mask_key       = mask_q ? key_q : '0;
    r.header_length  = seen;
    clear_parser();
    return r;
  endfunction

  function automatic wsh_pkg::result_t header_error(input logic [3:0] consumed);
    wsh_pkg::result_t r;
    r               = '0;
    r.status        = wsh_pkg::STATUS_ERROR;
    r.header_length = consumed;
    clear_parser();
    return r;
  endfunction

  // one byte into the parser; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output wsh_pkg::result_t r);
    logic [3:0] op;
    logic [6:0] len7;
    logic [3:0] ext_end;
    r = '0;
    case (ph)
      wsh_pkg::PH_FIRST: begin
        len_q = {56'd0, b};
        seen  = FIRST_BYTES;
        ph    = wsh_pkg::PH_SECOND;
      end
      wsh_pkg::PH_SECOND: begin
        op   = len_q[3:0];
        len7 = b[6:0];
        seen = wsh_pkg::HDR_BASE;
        if (len_q[6:4] != 3'b000 || op > wsh_pkg::OP_LAST ||
            (op >= wsh_pkg::OP_RSV_LO && op <= wsh_pkg::OP_RSV_HI)) begin
          r = header_error(wsh_pkg::HDR_BASE);
          return 1'b1;
        end
        fin_q  = len_q[7];
        op_q   = op;
        mask_q = b[7];
        need   = wsh_pkg::HDR_BASE;
        if (len7 == wsh_pkg::LEN16_CODE) begin
          need  = need + wsh_pkg::EXT16_BYTES;
          len_q = '0;
          ph    = wsh_pkg::PH_EXT;
        end else if (len7 == wsh_pkg::LEN64_CODE) begin
          need  = need + wsh_pkg::EXT64_BYTES;
          len_q = '0;
          ph    = wsh_pkg::PH_EXT;
        end else begin
          len_q = {57'd0, len7};
          ph    = wsh_pkg::PH_KEY;
        end
        if (mask_q) need = need + wsh_pkg::KEY_BYTES;
        if (seen >= need) begin
          r = header_done();
          return 1'b1;
        end
      end
      wsh_pkg::PH_EXT: begin
        ext_end = mask_q ? need - wsh_pkg::KEY_BYTES : need;
        len_q   = {len_q[55:0], b};
        seen    = seen + 4'd1;
        if (seen >= ext_end) begin
          if (ext_end == wsh_pkg::EXT64_END && len_q[63]) begin
            r = header_error(seen);
            return 1'b1;
          end
          ph = wsh_pkg::PH_KEY;
          if (seen >= need) begin
            r = header_done();
            return 1'b1;
          end
        end
      end
      default: begin
        key_q = {key_q[23:0], b};
        seen  = seen + 4'd1;
        if (seen >= need) begin
          r = header_done();
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    wsh_pkg::result_t r;
    wsh_pkg::result_t want;
    if (rst) begin
      clear_parser();
      expected_headers.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, r)) expected_headers.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_headers.size() == 0) begin
          report("result with no header pending", {63'd0, m_axis_tuser}, '0);
        end else begin
          want = expected_headers.pop_front();
          if (m_axis_tuser !== want.status)
            report("status", 64'(m_axis_tuser), 64'(want.status));
          if (m_axis_tdata[0] !== want.final_fragment)
            report("final_fragment", 64'(m_axis_tdata[0]), 64'(want.final_fragment));
          if (m_axis_tdata[4:1] !== want.frame_opcode)
            report("frame_opcode", 64'(m_axis_tdata[4:1]), 64'(want.frame_opcode));
          if (m_axis_tdata[5] !== want.is_masked)
            report("is_masked", 64'(m_axis_tdata[5]), 64'(want.is_masked));
          if (m_axis_tdata[68:6] !== want.payload_length)
            report("payload_length", 64'(m_axis_tdata[68:6]), 64'(want.payload_length));
          if (m_axis_tdata[100:69] !== want.mask_key)
            report("mask_key", 64'(m_axis_tdata[100:69]), 64'(want.mask_key));
          if (m_axis_tdata[104:101] !== want.header_length)
            report("header_length", 64'(m_axis_tdata[104:101]), 64'(want.header_length));
          if (m_axis_tdata[111:105] !== 7'd0)
            report("tdata padding", 64'(m_axis_tdata[111:105]), '0);
        end
      end
    end
    outstanding = expected_headers.size();
  end

endmodule

FILE: sim/websocket_header_parser_tb.sv
// testbench top for the websocket header parser: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module websocket_header_parser_tb;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam int BYTE_COUNT  = 1900;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_START  = 1200;
  localparam int CALM_END    = 1700;
  localparam int DRAIN       = 8;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;      // data_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;           // final_fragment, frame_opcode, is_masked,
                                        // payload_length, mask_key, header_length
  logic         m_axis_tuser;           // status

  int errors;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  int hold = 0;
  logic calm;

  assign calm = cycles >= CALM_START && cycles < CALM_END;

  websocket_header_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  websocket_header_parser_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("websocket_header_parser_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off so the parser backs up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (cycles == HOLD_START) begin
      hold <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // sends the two leading bytes and then whatever the header still needs
  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1, input bit oversize);
    logic [3:0] op;
    logic [7:0] ext0;
    int ext;
    op = b0[3:0];
    push_byte(b0);
    push_byte(b1);
    if (b0[6:4] != 3'b000 || op > wsh_pkg::OP_LAST ||
        (op >= wsh_pkg::OP_RSV_LO && op <= wsh_pkg::OP_RSV_HI)) return;
    ext = (b1[6:0] == wsh_pkg::LEN16_CODE) ? 2 : (b1[6:0] == wsh_pkg::LEN64_CODE) ? 8 : 0;
    if (ext > 0) begin
      ext0 = 8'($urandom);
      if (ext == 8 && !oversize) ext0[7] = 1'b0;
      push_byte(ext0);
      for (int i = 1; i < ext; i++) push_byte(8'($urandom));
      if (ext == 8 && ext0[7]) return;
    end
    if (b1[7]) begin
      for (int i = 0; i < 4; i++) push_byte(8'($urandom));
    end
  endtask

  task automatic send_frame();
    logic [3:0] op;
    logic [6:0] len7;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      case ($urandom_range(5))
        0: op = OP_CONT;
        1: op = OP_TEXT;
        2: op = OP_BIN;
        3: op = OP_CLOSE;
        4: op = OP_PING;
        default: op = OP_PONG;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4: len7 = 7'($urandom_range(125));
        5, 6, 7:       len7 = wsh_pkg::LEN16_CODE;
        default:       len7 = wsh_pkg::LEN64_CODE;
      endcase
      send_header({1'($urandom_range(1)), 3'b000, op}, {1'($urandom_range(1)), len7},
                  $urandom_range(9) == 0);
    end else begin
      // random leading bytes: mostly reserved bits or opcodes
      send_header(8'($urandom), 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = '{8'h81, 8'h05,
                 8'h70, 8'h80,
                 8'h0B, 8'h00,
                 8'h03, 8'h7F,
                 8'h82, 8'hFE, 8'h00, 8'h7E, 8'h12, 8'h34, 8'h56, 8'h78,
                 8'h88, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) push_byte(directed[i]);
    // legal 64-bit extremes: a masked fourteen-byte header and an unmasked ten-byte header
    push_byte(8'h8A);
    push_byte(8'hFF);
    push_byte(8'h7F);
    repeat (7) push_byte(8'hFF);
    repeat (4) push_byte(8'hFF);
    push_byte(8'h09);
    push_byte(8'h7F);
    repeat (8) push_byte(8'h00);
    while (sent < BYTE_COUNT) send_frame();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("websocket_header_parser_tb: clean");
    end else begin
      $display("websocket_header_parser_tb: errors");
    end
    $finish;
  end

endmodule
